[design/mpc_pkg.sv]
// shared constants, types and codes for the multiset permutation counter
// no dependencies
package mpc_pkg;

  localparam int DIGIT_COUNT   = 160;
  localparam int MAX_LETTERS   = 100;
  localparam int ALPHABET_SIZE = 26;
  localparam int GROUP_DIGITS  = 16;
  localparam int MAX_GROUPS    = 10;
  localparam int ALL_GROUPS    = (DIGIT_COUNT + GROUP_DIGITS - 1) / GROUP_DIGITS;
  localparam int OUT_GROUPS    = (ALL_GROUPS < MAX_GROUPS) ? ALL_GROUPS : MAX_GROUPS;

  localparam int CNTW  = 7;
  localparam int LW    = $clog2(ALPHABET_SIZE);
  localparam int IDXW  = $clog2(DIGIT_COUNT);
  localparam int OIDXW = $clog2(OUT_GROUPS * GROUP_DIGITS);
  localparam int GBITS = $clog2(GROUP_DIGITS);
  localparam int GRPW  = 4 * GROUP_DIGITS;

  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [CNTW-1:0] total;
    logic            overflow;
  } cnt_status_t;

  typedef struct packed {
    logic            op;
    logic [3:0]      a;
    logic [3:0]      b;
    logic [CNTW-1:0] k;
    logic [CNTW-1:0] cin;
  } alu_in_t;

  typedef struct packed {
    logic [3:0]      digit;
    logic [CNTW-1:0] cout;
  } alu_out_t;

endpackage

[design/mpc_ram.sv]
// generic single write port, single registered read port memory
// no dependencies
module mpc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mpc_letter_count.sv]
// per-letter counters, word total and overflow flag
// depends on mpc_pkg
module mpc_letter_count (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      inc,
  input  logic [4:0]                letter,
  input  logic                      clear,
  input  logic [mpc_pkg::LW-1:0]    rd_idx,
  output logic [mpc_pkg::CNTW-1:0]  rd_count,
  output mpc_pkg::cnt_status_t      status
);

  logic [mpc_pkg::CNTW-1:0] counts_r [mpc_pkg::ALPHABET_SIZE];
  logic [mpc_pkg::CNTW-1:0] total_r;
  logic                     ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int a = 0; a < mpc_pkg::ALPHABET_SIZE; a++) begin
        counts_r[a] <= '0;
      end
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (inc && (int'(letter) < mpc_pkg::ALPHABET_SIZE)) begin
      if (total_r >= mpc_pkg::CNTW'(mpc_pkg::MAX_LETTERS)) begin
        ovf_r <= 1'b1;
      end else begin
        total_r <= total_r + 1'b1;
        for (int a = 0; a < mpc_pkg::ALPHABET_SIZE; a++) begin
          if (int'(letter) == a) begin
            counts_r[a] <= counts_r[a] + 1'b1;
          end
        end
      end
    end
  end

  assign rd_count        = counts_r[rd_idx];
  assign status.total    = total_r;
  assign status.overflow = ovf_r;

endmodule

[design/mpc_digit_alu.sv]
// shared decimal digit unit: digit times small factor plus carry, or digit subtract with borrow
// depends on mpc_pkg
module mpc_digit_alu (
  input  mpc_pkg::alu_in_t  alu_i,
  output mpc_pkg::alu_out_t alu_o
);

  logic [10:0] v;
  logic [23:0] prod;
  logic [10:0] q;
  logic [10:0] r;
  logic [5:0]  t;

  always_comb begin
    v    = 11'(alu_i.a) * 11'(alu_i.k) + 11'(alu_i.cin);
    // divide by ten through reciprocal multiply
    prod = 24'(v) * 24'd6554;
    q    = 11'(prod >> 16);
    r    = v - 11'(q * 11'd10);
    t    = 6'(alu_i.a) - 6'(alu_i.b) - 6'(alu_i.cin[0]);
    if (alu_i.op == mpc_pkg::ALU_SUB) begin
      alu_o.digit = t[5] ? 4'(t + 6'd10) : t[3:0];
      alu_o.cout  = mpc_pkg::CNTW'(t[5]);
    end else begin
      alu_o.digit = r[3:0];
      alu_o.cout  = q[mpc_pkg::CNTW-1:0];
    end
  end

endmodule

[design/mpc_engine.sv]
// sequencer for factorial products, long division and group output over digit memories
// depends on mpc_pkg, mpc_ram, mpc_digit_alu
module mpc_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  mpc_pkg::cnt_status_t          status,
  input  logic [mpc_pkg::CNTW-1:0]      cnt_rd,
  output logic [mpc_pkg::LW-1:0]        cnt_rd_idx,
  output logic                          clear,
  output logic                          busy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mpc_pkg::GRPW-1:0]      out_tdata,
  output logic [0:0]                    out_tuser,
  output logic                          out_tlast
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_NEXT  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_SUB   = 4'd8;
  localparam logic [3:0] S_QWR   = 4'd9;
  localparam logic [3:0] S_OLOAD = 4'd10;
  localparam logic [3:0] S_OSEND = 4'd11;

  localparam logic [mpc_pkg::IDXW-1:0]  IDX_LAST  = mpc_pkg::IDXW'(mpc_pkg::DIGIT_COUNT - 1);
  localparam logic [mpc_pkg::LW-1:0]    LIDX_LAST = mpc_pkg::LW'(mpc_pkg::ALPHABET_SIZE - 1);
  localparam logic [mpc_pkg::OIDXW-1:0] OTOP      =
    mpc_pkg::OIDXW'(mpc_pkg::OUT_GROUPS * mpc_pkg::GROUP_DIGITS - 1);

  logic [3:0]                  state_r, state_nxt;
  logic [mpc_pkg::IDXW-1:0]    rd_idx_r, rd_idx_nxt, d_idx_r, d_idx_nxt;
  logic                        iss_r, iss_nxt, dv_r, dv_nxt;
  logic [mpc_pkg::CNTW-1:0]    carry_r, carry_nxt;
  logic                        phase_den_r, phase_den_nxt;
  logic [mpc_pkg::LW-1:0]      lidx_r, lidx_nxt;
  logic [7:0]                  k_r, k_nxt;
  logic                        cb_r, cb_nxt;
  logic [3:0]                  top_r, top_nxt, q_r, q_nxt;
  logic [mpc_pkg::IDXW-1:0]    i_r, i_nxt;
  logic                        big_r, big_nxt, src_num_r, src_num_nxt;
  logic [mpc_pkg::OIDXW-1:0]   oidx_r, oidx_nxt, od_idx_r, od_idx_nxt;
  logic                        ois_r, ois_nxt, odv_r, odv_nxt, od_inr_r, od_inr_nxt;
  logic [mpc_pkg::GRPW-1:0]    grp_r, grp_nxt;
  logic                        started_r, started_nxt;
  logic                        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic                        out_ovf_r, out_ovf_nxt;
  logic [mpc_pkg::GRPW-1:0]    out_data_r, out_data_nxt;

  logic                        start_pass, start_out, pass_st, pass_done, in_div;
  logic [8:0]                  lim;
  logic [3:0]                  odigit;

  logic                        num_we, den_we, rem_we, rem_wbank, quo_we;
  logic [mpc_pkg::IDXW-1:0]    num_waddr, rem_waddr, num_raddr, oaddr;
  logic [3:0]                  num_wdata, rem_wdata;
  logic [3:0]                  num_q, den_q, rem0_q, rem1_q, rem_q, quo_q;

  mpc_pkg::alu_in_t            alu_i;
  mpc_pkg::alu_out_t           alu_o;

  mpc_digit_alu u_alu (.alu_i(alu_i), .alu_o(alu_o));

  mpc_ram #(.DEPTH(mpc_pkg::DIGIT_COUNT), .WIDTH(4)) u_num (
    .clk(clk), .we(num_we), .waddr(num_waddr), .wdata(num_wdata),
    .raddr(num_raddr), .rdata(num_q));
  mpc_ram #(.DEPTH(mpc_pkg::DIGIT_COUNT), .WIDTH(4)) u_den (
    .clk(clk), .we(den_we), .waddr(num_waddr), .wdata(num_wdata),
    .raddr(rd_idx_r), .rdata(den_q));
  mpc_ram #(.DEPTH(mpc_pkg::DIGIT_COUNT), .WIDTH(4)) u_rem0 (
    .clk(clk), .we(rem_we && !rem_wbank), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(rd_idx_r), .rdata(rem0_q));
  mpc_ram #(.DEPTH(mpc_pkg::DIGIT_COUNT), .WIDTH(4)) u_rem1 (
    .clk(clk), .we(rem_we && rem_wbank), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(rd_idx_r), .rdata(rem1_q));
  mpc_ram #(.DEPTH(mpc_pkg::DIGIT_COUNT), .WIDTH(4)) u_quo (
    .clk(clk), .we(quo_we), .waddr(i_r), .wdata(q_r),
    .raddr(oaddr), .rdata(quo_q));

  assign rem_q     = cb_r ? rem1_q : rem0_q;
  assign in_div    = (state_r == S_SHIFT) || (state_r == S_INS);
  assign oaddr     = mpc_pkg::IDXW'(32'(oidx_r));
  assign num_raddr = (state_r == S_OLOAD) ? oaddr : (in_div ? i_r : rd_idx_r);
  assign pass_st   = (state_r == S_INIT) || (state_r == S_MUL) || (state_r == S_CHK) ||
                     (state_r == S_ZERO) || (state_r == S_SHIFT) || (state_r == S_SUB);
  assign pass_done = dv_r && (d_idx_r == IDX_LAST);
  assign lim       = phase_den_r ? 9'(cnt_rd) : 9'(status.total);
  assign odigit    = od_inr_r ? (src_num_r ? num_q : quo_q) : 4'd0;

  assign cnt_rd_idx = lidx_r;
  assign busy       = (state_r != S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    alu_i.op  = (state_r == S_SUB) ? mpc_pkg::ALU_SUB : mpc_pkg::ALU_MUL;
    alu_i.a   = (state_r == S_SUB) ? rem_q : (phase_den_r ? den_q : num_q);
    alu_i.b   = den_q;
    alu_i.k   = k_r[mpc_pkg::CNTW-1:0];
    alu_i.cin = carry_r;
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    d_idx_nxt     = d_idx_r;
    iss_nxt       = iss_r;
    dv_nxt        = dv_r;
    carry_nxt     = carry_r;
    phase_den_nxt = phase_den_r;
    lidx_nxt      = lidx_r;
    k_nxt         = k_r;
    cb_nxt        = cb_r;
    top_nxt       = top_r;
    q_nxt         = q_r;
    i_nxt         = i_r;
    big_nxt       = big_r;
    src_num_nxt   = src_num_r;
    oidx_nxt      = oidx_r;
    od_idx_nxt    = od_idx_r;
    ois_nxt       = ois_r;
    odv_nxt       = odv_r;
    od_inr_nxt    = od_inr_r;
    grp_nxt       = grp_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_data_nxt  = out_data_r;
    start_pass    = 1'b0;
    start_out     = 1'b0;
    clear         = 1'b0;
    num_we        = 1'b0;
    den_we        = 1'b0;
    num_waddr     = d_idx_r;
    num_wdata     = alu_o.digit;
    rem_we        = 1'b0;
    rem_wbank     = !cb_r;
    rem_waddr     = d_idx_r;
    rem_wdata     = alu_o.digit;
    quo_we        = 1'b0;

    if (pass_st) begin
      if (iss_r) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_idx_r == IDX_LAST) begin
          iss_nxt = 1'b0;
        end
      end
      dv_nxt    = iss_r;
      d_idx_nxt = rd_idx_r;
      if (dv_r) begin
        carry_nxt = alu_o.cout;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_INIT;
          start_pass = 1'b1;
        end
      end
      S_INIT: begin
        num_wdata = (d_idx_r == '0) ? 4'd1 : 4'd0;
        num_we    = dv_r;
        den_we    = dv_r;
        if (pass_done) begin
          phase_den_nxt = 1'b0;
          k_nxt         = 8'd2;
          state_nxt     = S_NEXT;
        end
      end
      S_NEXT: begin
        if (9'(k_r) <= lim) begin
          state_nxt  = S_MUL;
          start_pass = 1'b1;
        end else if (!phase_den_r) begin
          phase_den_nxt = 1'b1;
          lidx_nxt      = '0;
          k_nxt         = 8'd2;
        end else if (lidx_r == LIDX_LAST) begin
          big_nxt    = 1'b0;
          state_nxt  = S_CHK;
          start_pass = 1'b1;
        end else begin
          lidx_nxt = lidx_r + 1'b1;
          k_nxt    = 8'd2;
        end
      end
      S_MUL: begin
        num_we = dv_r && !phase_den_r;
        den_we = dv_r && phase_den_r;
        if (pass_done) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_CHK: begin
        if (dv_r) begin
          big_nxt = big_r | ((d_idx_r != '0) ? (den_q != 4'd0) : (den_q > 4'd1));
        end
        if (pass_done) begin
          if (big_nxt) begin
            i_nxt      = IDX_LAST;
            state_nxt  = S_ZERO;
            start_pass = 1'b1;
          end else begin
            src_num_nxt = 1'b1;
            start_out   = 1'b1;
            state_nxt   = S_OLOAD;
          end
        end
      end
      S_ZERO: begin
        rem_we    = dv_r;
        rem_wbank = cb_r;
        rem_wdata = 4'd0;
        if (pass_done) begin
          q_nxt      = 4'd0;
          state_nxt  = S_SHIFT;
          start_pass = 1'b1;
        end
      end
      S_SHIFT: begin
        rem_we    = dv_r && (d_idx_r != IDX_LAST);
        rem_waddr = d_idx_r + 1'b1;
        rem_wdata = rem_q;
        if (pass_done) begin
          top_nxt   = rem_q;
          cb_nxt    = !cb_r;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        rem_we     = 1'b1;
        rem_wbank  = cb_r;
        rem_waddr  = '0;
        rem_wdata  = num_q;
        state_nxt  = S_SUB;
        start_pass = 1'b1;
      end
      S_SUB: begin
        rem_we = dv_r;
        if (pass_done) begin
          if ((top_r != 4'd0) || !alu_o.cout[0]) begin
            cb_nxt     = !cb_r;
            top_nxt    = top_r - 4'(alu_o.cout[0]);
            q_nxt      = q_r + 1'b1;
            start_pass = 1'b1;
          end else begin
            state_nxt = S_QWR;
          end
        end
      end
      S_QWR: begin
        quo_we = 1'b1;
        if (i_r == '0) begin
          src_num_nxt = 1'b0;
          start_out   = 1'b1;
          state_nxt   = S_OLOAD;
        end else begin
          i_nxt      = i_r - 1'b1;
          q_nxt      = 4'd0;
          state_nxt  = S_SHIFT;
          start_pass = 1'b1;
        end
      end
      S_OLOAD: begin
        if (ois_r) begin
          oidx_nxt = oidx_r - 1'b1;
          if (oidx_r[mpc_pkg::GBITS-1:0] == '0) begin
            ois_nxt = 1'b0;
          end
        end
        odv_nxt    = ois_r;
        od_idx_nxt = oidx_r;
        od_inr_nxt = (32'(oidx_r) < mpc_pkg::DIGIT_COUNT);
        if (odv_r) begin
          grp_nxt = {grp_r[mpc_pkg::GRPW-5:0], odigit};
          if (od_idx_r[mpc_pkg::GBITS-1:0] == '0) begin
            odv_nxt = 1'b0;
            if ((grp_nxt == '0) && !started_r && (32'(od_idx_r) >= mpc_pkg::GROUP_DIGITS)) begin
              ois_nxt = 1'b1;
            end else begin
              out_data_nxt  = grp_nxt;
              out_last_nxt  = (32'(od_idx_r) < mpc_pkg::GROUP_DIGITS);
              out_ovf_nxt   = status.overflow;
              out_valid_nxt = 1'b1;
              started_nxt   = 1'b1;
              state_nxt     = S_OSEND;
            end
          end
        end
      end
      S_OSEND: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            clear     = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ois_nxt   = 1'b1;
            state_nxt = S_OLOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_pass) begin
      rd_idx_nxt = '0;
      iss_nxt    = 1'b1;
      dv_nxt     = 1'b0;
      carry_nxt  = '0;
    end
    if (start_out) begin
      oidx_nxt    = OTOP;
      ois_nxt     = 1'b1;
      odv_nxt     = 1'b0;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= 1'b0;
      dv_r        <= 1'b0;
      ois_r       <= 1'b0;
      odv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cb_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      ois_r       <= ois_nxt;
      odv_r       <= odv_nxt;
      out_valid_r <= out_valid_nxt;
      cb_r        <= cb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    d_idx_r     <= d_idx_nxt;
    carry_r     <= carry_nxt;
    phase_den_r <= phase_den_nxt;
    lidx_r      <= lidx_nxt;
    k_r         <= k_nxt;
    top_r       <= top_nxt;
    q_r         <= q_nxt;
    i_r         <= i_nxt;
    big_r       <= big_nxt;
    src_num_r   <= src_num_nxt;
    oidx_r      <= oidx_nxt;
    od_idx_r    <= od_idx_nxt;
    od_inr_r    <= od_inr_nxt;
    grp_r       <= grp_nxt;
    started_r   <= started_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

[design/multiset_permutation_count_top.sv]
// letter item: taken while the sequencer is idle, and in_tready stays high after it
// end item: one pass over all digits per factor multiply, then per quotient digit one
// remainder shift pass over all digits, up to 10 trial subtract passes and a store of the digit,
// then a scan of each skipped leading group and of each sent group plus out_tready stalls;
// the shared digit unit handles one digit per cycle
// rst_n is synchronous active low and clears all counts, the flag and the sequencer
// depends on mpc_pkg, mpc_letter_count, mpc_engine
module multiset_permutation_count_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] letter
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digit_group
  output logic [0:0]  out_tuser,  // [0] overflow
  output logic        out_tlast
);

  logic                     in_xfer, busy, clear;
  logic [mpc_pkg::LW-1:0]   cnt_rd_idx;
  logic [mpc_pkg::CNTW-1:0] cnt_rd;
  mpc_pkg::cnt_status_t     status;

  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;

  mpc_letter_count u_cnt (
    .clk(clk), .rst_n(rst_n),
    .inc(in_xfer && !in_tlast), .letter(in_tdata[4:0]),
    .clear(clear), .rd_idx(cnt_rd_idx), .rd_count(cnt_rd), .status(status));

  mpc_engine u_eng (
    .clk(clk), .rst_n(rst_n),
    .start(in_xfer && in_tlast), .status(status),
    .cnt_rd(cnt_rd), .cnt_rd_idx(cnt_rd_idx), .clear(clear), .busy(busy),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast));

endmodule

[test/multiset_permutation_count_top_test.sv]
// self-checking testbench for multiset_permutation_count_top: letter words in, BCD groups out
// predicts each word's arrangement count with BCD arithmetic of its own
// depends on mpc_pkg and the design sources
module multiset_permutation_count_top_test;

  typedef logic [mpc_pkg::DIGIT_COUNT-1:0][3:0] bcd_t;
  typedef struct {
    logic [mpc_pkg::GRPW-1:0] digits;
    logic                     overflow;
    logic                     last;
  } group_t;

  localparam int WATCHDOG_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  logic [mpc_pkg::CNTW-1:0] letter_tally [mpc_pkg::ALPHABET_SIZE];
  logic [mpc_pkg::CNTW-1:0] word_length;
  logic                     word_overflow;
  group_t          pending_groups [$];
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  int              out_hold = 0;
  bit              quiet_input = 1'b0;
  bit              quiet_output = 1'b0;

  multiset_permutation_count_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bcd_t bcd_times(bcd_t a, int k);
    int carry;
    int v;
    carry = 0;
    for (int i = 0; i < mpc_pkg::DIGIT_COUNT; i++) begin
      v = int'(a[i]) * k + carry;
      a[i] = 4'(v % 10);
      carry = v / 10;
    end
    return a;
  endfunction

  function automatic bcd_t bcd_factorial_into(bcd_t a, int m);
    for (int i = 2; i <= m; i++) a = bcd_times(a, i);
    return a;
  endfunction

  function automatic bcd_t bcd_divide(bcd_t num, bcd_t den);
    bcd_t rem;
    bcd_t quo;
    logic [3:0] top;
    int q;
    int b;
    int v;
    rem = '0;
    quo = '0;
    for (int i = mpc_pkg::DIGIT_COUNT - 1; i >= 0; i--) begin
      top = rem[mpc_pkg::DIGIT_COUNT-1];
      rem = {rem[mpc_pkg::DIGIT_COUNT-2:0], num[i]};
      q = 0;
      while (top != 0 || rem >= den) begin
        b = 0;
        for (int j = 0; j < mpc_pkg::DIGIT_COUNT; j++) begin
          v = int'(rem[j]) - int'(den[j]) - b;
          if (v < 0) begin
            v += 10;
            b = 1;
          end else begin
            b = 0;
          end
          rem[j] = 4'(v);
        end
        top = top - 4'(b);
        q++;
      end
      quo[i] = 4'(q);
    end
    return quo;
  endfunction

  task automatic clear_word();
    foreach (letter_tally[i]) letter_tally[i] = '0;
    word_length = '0;
    word_overflow = 1'b0;
  endtask

  task automatic predict_arrangements(logic [4:0] code, logic is_end);
    bcd_t num;
    bcd_t den;
    bcd_t quo;
    bcd_t one;
    group_t g;
    bit started;
    if (!is_end) begin
      if (code >= mpc_pkg::ALPHABET_SIZE) return;
      if (word_length >= mpc_pkg::MAX_LETTERS) begin
        word_overflow = 1'b1;
        return;
      end
      letter_tally[code] = letter_tally[code] + 1'b1;
      word_length = word_length + 1'b1;
      return;
    end
    one = '0;
    one[0] = 4'd1;
    num = bcd_factorial_into(one, word_length);
    den = one;
    for (int i = 0; i < mpc_pkg::ALPHABET_SIZE; i++) begin
      den = bcd_factorial_into(den, letter_tally[i]);
    end
    if (den <= one) quo = num;
    else quo = bcd_divide(num, den);
    started = 1'b0;
    for (int gi = mpc_pkg::OUT_GROUPS - 1; gi >= 0; gi--) begin
      g.digits = quo[gi*mpc_pkg::GROUP_DIGITS +: mpc_pkg::GROUP_DIGITS];
      if (!started && g.digits == '0 && gi != 0) continue;
      started = 1'b1;
      g.overflow = word_overflow;
      g.last = (gi == 0);
      pending_groups.push_back(g);
    end
    clear_word();
  endtask

  task automatic send_item(logic [4:0] code, logic is_end);
    int gap;
    gap = quiet_input ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, code};
    in_tlast <= is_end;
    do @(posedge clk); while (!in_tready);
    predict_arrangements(code, is_end);
  endtask

  task automatic send_word(int length, int alpha);
    for (int i = 0; i < length; i++) send_item(5'($urandom_range(0, alpha - 1)), 1'b0);
    send_item(5'($urandom), 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else if (quiet_output) begin
      out_tready <= 1'b1;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      out_hold <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    group_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_groups.size() == 0) begin
        $error("unexpected transfer: digit_group %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_groups.pop_front();
        if (out_tdata !== want.digits) begin
          $error("digit_group expected %h actual %h", want.digits, out_tdata);
          mismatch_count++;
        end
        if (out_tuser[0] !== want.overflow) begin
          $error("overflow expected %b actual %b", want.overflow, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %b actual %b", want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_empty_and_short();
    send_item(5'd0, 1'b1);
    send_item(5'd0, 1'b0);
    send_item(5'd0, 1'b1);
    send_item(5'd25, 1'b0);
    send_item(5'd25, 1'b0);
    send_item(5'd0, 1'b0);
    send_item(5'd31, 1'b1);
    for (int c = mpc_pkg::ALPHABET_SIZE; c < 32; c++) send_item(5'(c), 1'b0);
    send_item(5'd1, 1'b0);
    send_item(5'd31, 1'b0);
    send_item(5'd2, 1'b0);
    send_item(5'd10, 1'b1);
  endtask

  task automatic test_long_words();
    quiet_input = 1'b1;
    quiet_output = 1'b1;
    for (int i = 0; i < mpc_pkg::MAX_LETTERS; i++) send_item(5'd7, 1'b0);
    send_item(5'd0, 1'b1);
    quiet_input = 1'b0;
    quiet_output = 1'b0;
    for (int i = 0; i < mpc_pkg::MAX_LETTERS + 5; i++) begin
      send_item(5'(i % mpc_pkg::ALPHABET_SIZE), 1'b0);
    end
    send_item(5'd0, 1'b1);
  endtask

  task automatic test_drained_pause();
    send_word(6, 3);
    wait_drained();
    send_word(4, 26);
  endtask

  task automatic test_random_words();
    int sent;
    int len;
    sent = 0;
    while (sent < 225) begin
      quiet_input = ($urandom_range(0, 5) == 0);
      quiet_output = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 29) == 0) len = $urandom_range(20, 40);
      else len = $urandom_range(0, 12);
      case ($urandom_range(0, 3))
        0: send_word(len, 32);
        1: send_word(len, $urandom_range(1, 4));
        default: begin
          for (int i = 0; i < len && i < mpc_pkg::ALPHABET_SIZE; i++) send_item(5'(i), 1'b0);
          send_item(5'($urandom), 1'b1);
        end
      endcase
      sent += len + 1;
    end
    quiet_input = 1'b0;
    quiet_output = 1'b0;
  endtask

  initial begin
    clear_word();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_short();
    test_long_words();
    test_drained_pause();
    test_random_words();
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
